FILE: src/fine_grained_thread_scheduler_assert.svh
// Assertion macros for the fine-grained thread scheduler.
`ifndef FINE_GRAINED_THREAD_SCHEDULER_ASSERT_SVH
`define FINE_GRAINED_THREAD_SCHEDULER_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define FGTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under synchronous reset.
`define FGTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/fgts_pkg.sv
// Shared types and constants for the fine-grained thread scheduler.
`timescale 1ns / 1ps

package fgts_pkg;

   localparam int MAX_THREADS_DEF = 8;
   localparam int MAX_ITEMS_DEF   = 65536;
   localparam int TIME_W          = 48;
   localparam int ITEM_W          = 16;
   localparam int END_W           = 17;
   localparam int TID_W           = 3;
   localparam int CSR_DATA_W      = 16;

   // Command codes carried by a request beat.
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_THREAD_COUNT = 2'd0,
      CSR_QUANTUM      = 2'd1,
      CSR_SWITCH_COST  = 2'd2,
      CSR_CYCLE_MODEL  = 2'd3
   } csr_index_type;

   // Register reset values.
   localparam logic [3:0]  THREAD_COUNT_RST = 4'd4;
   localparam logic [15:0] QUANTUM_RST      = 16'd16;
   localparam logic [15:0] SWITCH_COST_RST  = 16'd2;
   localparam logic        CYCLE_MODEL_RST  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clamp;
      logic div_step;
      logic fill_step;
      logic upd1;
      logic upd2;
      logic prep;
      logic scan_step;
      logic jump;
      logic respond;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_finish;
      logic active_has_work;
      logic div_last;
      logic fill_last;
      logic scan_hit;
      logic scan_last;
      logic jump_ok;
   } dp_status_type;

endpackage

FILE: src/fgts_datapath.sv
// Datapath of the scheduler: context tables, time, divider, scan and result registers.
`timescale 1ns / 1ps

module fgts_datapath #(
   parameter int MAX_THREADS = fgts_pkg::MAX_THREADS_DEF,
   parameter int MAX_ITEMS   = fgts_pkg::MAX_ITEMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fgts_pkg::ctl_cmd_type           cmd,
   output fgts_pkg::dp_status_type         status,
   input  logic                            req_command,
   input  logic [15:0]                     req_item_count,
   input  logic [fgts_pkg::TIME_W-1:0]     req_start_time,
   input  logic [15:0]                     req_compute_cycles,
   input  logic [15:0]                     req_stall_cycles,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [fgts_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            rsp_valid,
   output logic                            rsp_done_res,
   output logic [fgts_pkg::TID_W-1:0]      rsp_thread_id,
   output logic [fgts_pkg::ITEM_W-1:0]     rsp_item_index,
   output logic [fgts_pkg::TIME_W-1:0]     rsp_current_time,
   output logic [fgts_pkg::TIME_W-1:0]     rsp_idle_cycles,
   output logic                            rsp_switched
);

   localparam int IDXW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int UW   = $clog2(MAX_THREADS + 1);
   localparam int DW   = fgts_pkg::END_W;
   localparam int RW   = UW + 1;
   localparam int DCW  = $clog2(DW);
   localparam int ACW  = fgts_pkg::END_W + UW;
   localparam int TW   = fgts_pkg::TIME_W;
   localparam int IW   = fgts_pkg::ITEM_W;
   localparam int EW   = fgts_pkg::END_W;

   // Configuration registers.
   logic [3:0]  tc_ff, tc_in;
   logic [15:0] qc_ff, qc_in;
   logic [15:0] sc_ff, sc_in;
   logic        cme_ff, cme_in;

   // Captured request beat.
   logic          cmd_ff, cmd_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [TW-1:0] st_ff, st_in;
   logic [15:0]   comp_ff, comp_in;
   logic [15:0]   lat_ff, lat_in;

   // Stage setup: clamped counts, divider and chunk fill.
   logic [15:0]     n_ff, n_in;
   logic [UW-1:0]   use_ff, use_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [DCW-1:0]  dcnt_ff, dcnt_in;
   logic [IDXW-1:0] fidx_ff, fidx_in;
   logic [ACW-1:0]  acc_ff, acc_in;

   // Context tables.
   logic [IW-1:0] nxt_ff [MAX_THREADS];
   logic [IW-1:0] nxt_in [MAX_THREADS];
   logic [EW-1:0] end_ff [MAX_THREADS];
   logic [EW-1:0] end_in [MAX_THREADS];
   logic [TW-1:0] bu_ff  [MAX_THREADS];
   logic [TW-1:0] bu_in  [MAX_THREADS];
   logic [15:0]   ql_ff  [MAX_THREADS];
   logic [15:0]   ql_in  [MAX_THREADS];

   // Scheduler state.
   logic [TW-1:0]   now_ff, now_in;
   logic [IDXW-1:0] rot_ff, rot_in;
   logic [IDXW-1:0] act_ff, act_in;
   logic            sw_ff, sw_in;
   logic [15:0]     qtmp_ff, qtmp_in;

   // Scan state.
   logic [IDXW-1:0] sidx_ff, sidx_in;
   logic [IDXW-1:0] scnt_ff, scnt_in;
   logic            found_ff, found_in;
   logic [IDXW-1:0] pick_ff, pick_in;
   logic [IW-1:0]   pitem_ff, pitem_in;
   logic            any_ff, any_in;
   logic [TW-1:0]   wake_ff, wake_in;
   logic [TW-1:0]   idle_ff, idle_in;

   // Result registers.
   logic                       rv_ff, rv_in;
   logic                       rdone_ff, rdone_in;
   logic [fgts_pkg::TID_W-1:0] rtid_ff, rtid_in;
   logic [IW-1:0]              ritem_ff, ritem_in;
   logic [TW-1:0]              rtime_ff, rtime_in;
   logic [TW-1:0]              ridle_ff, ridle_in;
   logic                       rsw_ff, rsw_in;

   // Shared table read port and derived values.
   logic [IDXW-1:0] rd_idx;
   logic [IW-1:0]   rd_nxt;
   logic [EW-1:0]   rd_end;
   logic [TW-1:0]   rd_bu;
   logic [15:0]     rd_ql;
   logic            rd_hw;
   logic            hit;
   logic            jump_ok;
   logic [15:0]     n_c;
   logic [UW-1:0]   use_c;
   logic [RW-1:0]   rem_sh;
   logic [ACW-1:0]  sum_c;
   logic [ACW-1:0]  e_c;
   logic [ACW-1:0]  s_c;
   logic [UW-1:0]   act_p1;
   logic [UW-1:0]   sidx_p1;

   assign rd_idx  = (cmd.upd1 || cmd.upd2) ? act_ff : sidx_ff;
   assign rd_nxt  = nxt_ff[rd_idx];
   assign rd_end  = end_ff[rd_idx];
   assign rd_bu   = bu_ff[rd_idx];
   assign rd_ql   = ql_ff[rd_idx];
   assign rd_hw   = EW'(rd_nxt) < rd_end;
   assign hit     = rd_hw && (now_ff >= rd_bu);
   assign jump_ok = any_ff && (wake_ff > now_ff);
   assign act_p1  = UW'(act_ff) + UW'(1);
   assign sidx_p1 = UW'(sidx_ff) + UW'(1);
   assign rem_sh  = {rem_ff[RW-2:0], quo_ff[DW-1]};
   assign sum_c   = acc_ff + ACW'(quo_ff);
   assign e_c     = (sum_c > ACW'(n_ff)) ? ACW'(n_ff) : sum_c;
   assign s_c     = (acc_ff > e_c) ? e_c : acc_ff;

   // Clamp the item count and the context count for a new stage.
   always_comb begin
      n_c = cnt_ff;
      if (32'(cnt_ff) > 32'(MAX_ITEMS)) begin
         n_c = 16'(MAX_ITEMS);
      end
      use_c = UW'(tc_ff);
      if (32'(tc_ff) > 32'(MAX_THREADS)) begin
         use_c = UW'(MAX_THREADS);
      end
      if (32'(use_c) > 32'(n_c)) begin
         use_c = UW'(n_c);
      end
      if (use_c == '0) begin
         use_c = UW'(1);
      end
   end

   assign status.is_finish       = (cmd_ff == fgts_pkg::CMD_FINISH);
   assign status.active_has_work = rd_hw;
   assign status.div_last        = (dcnt_ff == DCW'(DW - 1));
   assign status.fill_last       = (fidx_ff == IDXW'(MAX_THREADS - 1));
   assign status.scan_hit        = hit;
   assign status.scan_last       = ((UW'(scnt_ff) + UW'(1)) == use_ff);
   assign status.jump_ok         = jump_ok;

   // Next-state logic of the whole datapath.
   always_comb begin
      tc_in = tc_ff;  qc_in = qc_ff;  sc_in = sc_ff;  cme_in = cme_ff;
      cmd_in = cmd_ff;  cnt_in = cnt_ff;  st_in = st_ff;
      comp_in = comp_ff;  lat_in = lat_ff;
      n_in = n_ff;  use_in = use_ff;  quo_in = quo_ff;  rem_in = rem_ff;
      dcnt_in = dcnt_ff;  fidx_in = fidx_ff;  acc_in = acc_ff;
      nxt_in = nxt_ff;  end_in = end_ff;  bu_in = bu_ff;  ql_in = ql_ff;
      now_in = now_ff;  rot_in = rot_ff;  act_in = act_ff;
      sw_in = sw_ff;  qtmp_in = qtmp_ff;
      sidx_in = sidx_ff;  scnt_in = scnt_ff;  found_in = found_ff;
      pick_in = pick_ff;  pitem_in = pitem_ff;  any_in = any_ff;
      wake_in = wake_ff;  idle_in = idle_ff;
      rv_in = 1'b0;  rdone_in = rdone_ff;  rtid_in = rtid_ff;
      ritem_in = ritem_ff;  rtime_in = rtime_ff;  ridle_in = ridle_ff;
      rsw_in = rsw_ff;

      // Configuration writes.
      if (csr_write) begin
         case (fgts_pkg::csr_index_type'(csr_index))
            fgts_pkg::CSR_THREAD_COUNT: tc_in  = csr_data[3:0];
            fgts_pkg::CSR_QUANTUM:      qc_in  = csr_data;
            fgts_pkg::CSR_SWITCH_COST:  sc_in  = csr_data;
            fgts_pkg::CSR_CYCLE_MODEL:  cme_in = csr_data[0];
            default:                    tc_in  = tc_ff;
         endcase
      end

      // Capture the request beat.
      if (cmd.accept) begin
         cmd_in  = req_command;
         cnt_in  = req_item_count;
         st_in   = req_start_time;
         comp_in = req_compute_cycles;
         lat_in  = req_stall_cycles;
         sw_in   = 1'b0;
      end

      // Stage start: clamp, load the divider, reset the scheduler state.
      if (cmd.clamp) begin
         n_in    = n_c;
         use_in  = use_c;
         quo_in  = DW'(n_c) + DW'(use_c) - DW'(1);
         rem_in  = '0;
         dcnt_in = '0;
         fidx_in = '0;
         acc_in  = '0;
         now_in  = st_ff;
         rot_in  = '0;
         act_in  = '0;
      end

      // One restoring division step per cycle: chunk = ceil(n / use).
      if (cmd.div_step) begin
         if (rem_sh >= RW'(use_ff)) begin
            rem_in = rem_sh - RW'(use_ff);
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff + DCW'(1);
      end

      // Lay out one context's chunk per cycle.
      if (cmd.fill_step) begin
         if (32'(fidx_ff) < 32'(use_ff)) begin
            nxt_in[fidx_ff] = IW'(s_c);
            end_in[fidx_ff] = EW'(e_c);
         end else begin
            nxt_in[fidx_ff] = '0;
            end_in[fidx_ff] = '0;
         end
         bu_in[fidx_ff] = '0;
         ql_in[fidx_ff] = qc_ff;
         acc_in  = sum_c;
         fidx_in = fidx_ff + IDXW'(1);
      end

      // Finish, first half: charge compute time and draw down the quantum.
      if (cmd.upd1 && rd_hw && cme_ff) begin
         now_in  = now_ff + TW'(comp_ff);
         qtmp_in = (comp_ff >= rd_ql) ? 16'd0 : (rd_ql - comp_ff);
      end

      // Finish, second half: stall, forced switch and rotation.
      if (cmd.upd2) begin
         if (cme_ff) begin
            if (lat_ff != 16'd0) begin
               bu_in[act_ff] = now_ff + TW'(lat_ff);
            end
            if (qtmp_ff == 16'd0) begin
               now_in        = now_ff + TW'(sc_ff);
               ql_in[act_ff] = qc_ff;
               rot_in        = (act_p1 == use_ff) ? '0 : IDXW'(act_p1);
               sw_in         = 1'b1;
            end else begin
               ql_in[act_ff] = qtmp_ff;
               rot_in        = act_ff;
            end
         end else begin
            rot_in = (act_p1 == use_ff) ? '0 : IDXW'(act_p1);
         end
         nxt_in[act_ff] = rd_nxt + IW'(1);
      end

      // Open a selection pass.
      if (cmd.prep) begin
         sidx_in  = rot_ff;
         scnt_in  = '0;
         found_in = 1'b0;
         any_in   = 1'b0;
         wake_in  = '0;
         idle_in  = '0;
      end

      // Visit one context in round-robin order per cycle.
      if (cmd.scan_step) begin
         if (hit) begin
            found_in = 1'b1;
            pick_in  = sidx_ff;
            pitem_in = rd_nxt;
         end
         if (rd_hw && (!any_ff || (rd_bu < wake_ff))) begin
            wake_in = rd_bu;
            any_in  = 1'b1;
         end
         sidx_in = (sidx_p1 == use_ff) ? '0 : IDXW'(sidx_p1);
         scnt_in = scnt_ff + IDXW'(1);
      end

      // Every context with work is blocked: skip ahead to the earliest wake.
      if (cmd.jump && jump_ok) begin
         idle_in  = wake_ff - now_ff;
         now_in   = wake_ff;
         sidx_in  = rot_ff;
         scnt_in  = '0;
         found_in = 1'b0;
         any_in   = 1'b0;
      end

      // Load the result beat.
      if (cmd.respond) begin
         rv_in    = 1'b1;
         rdone_in = !found_ff;
         rtid_in  = found_ff ? fgts_pkg::TID_W'(pick_ff) : '0;
         ritem_in = found_ff ? pitem_ff : '0;
         rtime_in = now_ff;
         ridle_in = found_ff ? idle_ff : '0;
         rsw_in   = sw_ff;
         if (found_ff) begin
            act_in = pick_ff;
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff    <= fgts_pkg::THREAD_COUNT_RST;
         qc_ff    <= fgts_pkg::QUANTUM_RST;
         sc_ff    <= fgts_pkg::SWITCH_COST_RST;
         cme_ff   <= fgts_pkg::CYCLE_MODEL_RST;
         use_ff   <= UW'(1);
         now_ff   <= '0;
         rot_ff   <= '0;
         act_ff   <= '0;
         sw_ff    <= 1'b0;
         found_ff <= 1'b0;
         rv_ff    <= 1'b0;
         for (int t = 0; t < MAX_THREADS; t++) begin
            nxt_ff[t] <= '0;
            end_ff[t] <= '0;
            bu_ff[t]  <= '0;
            ql_ff[t]  <= '0;
         end
      end else begin
         tc_ff    <= tc_in;
         qc_ff    <= qc_in;
         sc_ff    <= sc_in;
         cme_ff   <= cme_in;
         use_ff   <= use_in;
         now_ff   <= now_in;
         rot_ff   <= rot_in;
         act_ff   <= act_in;
         sw_ff    <= sw_in;
         found_ff <= found_in;
         rv_ff    <= rv_in;
         nxt_ff   <= nxt_in;
         end_ff   <= end_in;
         bu_ff    <= bu_in;
         ql_ff    <= ql_in;
      end
      cmd_ff   <= cmd_in;
      cnt_ff   <= cnt_in;
      st_ff    <= st_in;
      comp_ff  <= comp_in;
      lat_ff   <= lat_in;
      n_ff     <= n_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      fidx_ff  <= fidx_in;
      acc_ff   <= acc_in;
      qtmp_ff  <= qtmp_in;
      sidx_ff  <= sidx_in;
      scnt_ff  <= scnt_in;
      pick_ff  <= pick_in;
      pitem_ff <= pitem_in;
      any_ff   <= any_in;
      wake_ff  <= wake_in;
      idle_ff  <= idle_in;
      rdone_ff <= rdone_in;
      rtid_ff  <= rtid_in;
      ritem_ff <= ritem_in;
      rtime_ff <= rtime_in;
      ridle_ff <= ridle_in;
      rsw_ff   <= rsw_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_done_res     = rdone_ff;
   assign rsp_thread_id    = rtid_ff;
   assign rsp_item_index   = ritem_ff;
   assign rsp_current_time = rtime_ff;
   assign rsp_idle_cycles  = ridle_ff;
   assign rsp_switched     = rsw_ff;

endmodule

FILE: src/fgts_ctrl.sv
// Control state machine that sequences the scheduler datapath.
`timescale 1ns / 1ps

module fgts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  fgts_pkg::dp_status_type status,
   output fgts_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_CLAMP = 10'b00_0000_0010,
      ST_DIV   = 10'b00_0000_0100,
      ST_FILL  = 10'b00_0000_1000,
      ST_UPD1  = 10'b00_0001_0000,
      ST_UPD2  = 10'b00_0010_0000,
      ST_PREP  = 10'b00_0100_0000,
      ST_SCAN  = 10'b00_1000_0000,
      ST_JUMP  = 10'b01_0000_0000,
      ST_RESP  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   // Command decode and next state.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (status.is_finish) begin
               state_in = ST_UPD1;
            end else begin
               cmd.clamp = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_PREP;
            end
         end
         ST_UPD1: begin
            cmd.upd1 = 1'b1;
            state_in = status.active_has_work ? ST_UPD2 : ST_PREP;
         end
         ST_UPD2: begin
            cmd.upd2 = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               state_in = ST_RESP;
            end else if (status.scan_last) begin
               state_in = ST_JUMP;
            end
         end
         ST_JUMP: begin
            cmd.jump = 1'b1;
            state_in = status.jump_ok ? ST_SCAN : ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/fine_grained_thread_scheduler.sv
// Top level of the fine-grained round-robin thread scheduler.
//
//   channel  ports                          handshake
//   request  start, busy, req_*             taken when start is high and busy is low
//   result   rsp_valid, rsp_*               one beat per request, one cycle, no stall
//   config   csr_valid, csr_ready, csr_*    written when csr_valid and csr_ready are high
//
// A start beat runs setup (decode, one divider bit per cycle, one context laid out
// per cycle); a finish beat runs decode and updates. Selection then visits one
// context per cycle, with a jump between passes while all contexts with work are
// blocked, and the result beat is shown in the first cycle with busy low.
// Reset clears the tables and time and sets the configuration registers to their defaults.
// The result side cannot stall, so no beat is ever held back.
`timescale 1ns / 1ps

module fine_grained_thread_scheduler #(
   parameter int MAX_THREADS = fgts_pkg::MAX_THREADS_DEF,
   parameter int MAX_ITEMS   = fgts_pkg::MAX_ITEMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_command,
   input  logic [15:0]                     req_item_count,
   input  logic [fgts_pkg::TIME_W-1:0]     req_start_time,
   input  logic [15:0]                     req_compute_cycles,
   input  logic [15:0]                     req_stall_cycles,
   output logic                            rsp_valid,
   output logic                            rsp_done_res,
   output logic [fgts_pkg::TID_W-1:0]      rsp_thread_id,
   output logic [fgts_pkg::ITEM_W-1:0]     rsp_item_index,
   output logic [fgts_pkg::TIME_W-1:0]     rsp_current_time,
   output logic [fgts_pkg::TIME_W-1:0]     rsp_idle_cycles,
   output logic                            rsp_switched,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [fgts_pkg::CSR_DATA_W-1:0] csr_data
);

`include "fine_grained_thread_scheduler_assert.svh"

   fgts_pkg::ctl_cmd_type   cmd;
   fgts_pkg::dp_status_type status;

   // Registers are always writable.
   assign csr_ready = 1'b1;

   fgts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   fgts_datapath #(
      .MAX_THREADS (MAX_THREADS),
      .MAX_ITEMS   (MAX_ITEMS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_command        (req_command),
      .req_item_count     (req_item_count),
      .req_start_time     (req_start_time),
      .req_compute_cycles (req_compute_cycles),
      .req_stall_cycles   (req_stall_cycles),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_done_res       (rsp_done_res),
      .rsp_thread_id      (rsp_thread_id),
      .rsp_item_index     (rsp_item_index),
      .rsp_current_time   (rsp_current_time),
      .rsp_idle_cycles    (rsp_idle_cycles),
      .rsp_switched       (rsp_switched)
   );

   // A taken request keeps the block busy until its result is loaded.
   `FGTS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   // A result beat is shown only once the work has ended.
   `FGTS_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   // A done result names no context, item or idle time.
   `FGTS_ASSERT_IMPLY(a_done_clear, clock, reset, rsp_valid && rsp_done_res,
      rsp_thread_id == '0 && rsp_item_index == '0 && rsp_idle_cycles == '0,
      "done result carries a choice")

endmodule
